[src/lbc_pkg.sv]
// Package for the block buffer cache: sizes, codes and the structs that pass
// between the top level and the row of entry cells. No dependencies.
package lbc_pkg;

  // Number of cache entries and the widths that follow from it.
  localparam int SLOTS  = 32;
  localparam int RANK_W = $clog2(SLOTS);

  // Fixed field widths of the request and response items.
  localparam int SLOT_W  = 5;
  localparam int DEV_W   = 8;
  localparam int BLK_W   = 32;
  localparam int COUNT_W = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    CMD_GET     = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_PIN     = 2'd2,
    CMD_UNPIN   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_NO_FREE  = 2'd1,
    ERR_UNDERFLOW = 2'd2,
    ERR_OVERFLOW = 2'd3
  } err_e;

  // Operation applied to the selected cell in the update cycle.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_HIT,
    OP_FILL,
    OP_INC,
    OP_DEC,
    OP_FRONT
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_DECIDE
  } state_e;

  typedef struct packed {
    cmd_e               command;
    logic [DEV_W-1:0]   device;
    logic [BLK_W-1:0]   block_number;
    logic [SLOT_W-1:0]  slot_in;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot_out;
    logic               need_read;
    logic               hit;
    logic [COUNT_W-1:0] ref_count_out;
    err_e               error;
  } rsp_t;

  // Update broadcast from the top level to every cell.
  typedef struct packed {
    cell_op_e           op;
    logic [DEV_W-1:0]   device;
    logic [BLK_W-1:0]   block_number;
    logic               shift;
    logic [RANK_W-1:0]  old_rank;
  } upd_t;

  // Status reported by each cell; the flags are decoded by rank.
  typedef struct packed {
    logic [SLOTS-1:0]   match_by_rank;
    logic [SLOTS-1:0]   free_by_rank;
    logic [COUNT_W-1:0] count;
    logic               valid;
    logic [RANK_W-1:0]  rank;
  } stat_t;

endpackage

[src/lbc_cell.sv]
// One cache entry: tags, valid bit, reference count and recency rank.
// Depends on lbc_pkg for the update and status structs.
module lbc_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [lbc_pkg::RANK_W-1:0] rank_init,
  input  logic [lbc_pkg::DEV_W-1:0]  key_device,
  input  logic [lbc_pkg::BLK_W-1:0]  key_block,
  input  lbc_pkg::upd_t              upd,
  input  logic                       sel,
  output lbc_pkg::stat_t             stat
);

  logic [lbc_pkg::DEV_W-1:0]   tag_device;
  logic [lbc_pkg::BLK_W-1:0]   tag_block;
  logic                        entry_valid;
  logic [lbc_pkg::COUNT_W-1:0] ref_count;
  logic [lbc_pkg::RANK_W-1:0]  recency_rank;
  logic                        match;
  logic                        free;

  // Tag compare and free test, reported as one-hot flags at this cell's rank.
  always_comb begin
    match = (tag_device == key_device) && (tag_block == key_block);
    free  = (ref_count == '0);
    stat.match_by_rank = match ? (lbc_pkg::SLOTS'(1) << recency_rank) : '0;
    stat.free_by_rank  = free  ? (lbc_pkg::SLOTS'(1) << recency_rank) : '0;
    stat.count = ref_count;
    stat.valid = entry_valid;
    stat.rank  = recency_rank;
  end

  // Entry update; an entry moved to the front pushes younger ranks down.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_device   <= '0;
      tag_block    <= '0;
      entry_valid  <= 1'b0;
      ref_count    <= '0;
      recency_rank <= rank_init;
    end else begin
      if (sel) begin
        case (upd.op)
          lbc_pkg::OP_HIT: begin
            ref_count   <= ref_count + 1'b1;
            entry_valid <= 1'b1;
          end
          lbc_pkg::OP_FILL: begin
            tag_device  <= upd.device;
            tag_block   <= upd.block_number;
            ref_count   <= lbc_pkg::COUNT_W'(1);
            entry_valid <= 1'b1;
          end
          lbc_pkg::OP_INC: begin
            ref_count <= ref_count + 1'b1;
          end
          lbc_pkg::OP_DEC: begin
            ref_count <= ref_count - 1'b1;
          end
          lbc_pkg::OP_FRONT: begin
            ref_count    <= ref_count - 1'b1;
            recency_rank <= '0;
          end
          default: begin
          end
        endcase
      end else if (upd.shift && (recency_rank < upd.old_rank)) begin
        recency_rank <= recency_rank + 1'b1;
      end
    end
  end

endmodule

[src/lru_block_buffer_cache_top.sv]
// Block buffer cache with reference counts and least-recently-released reuse.
// A request is taken in the idle state with its tag compare captured; the update and the
// response register follow in the decide state, and the next request waits for idle.
// A stalled response holds the block in its update cycle until it is taken.
// Synchronous reset clears all tags, valid bits and counts; slot i gets rank SLOTS-1-i.
// Depends on lbc_pkg and lbc_cell.
module lru_block_buffer_cache_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  lbc_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output lbc_pkg::rsp_t rsp
);

  lbc_pkg::state_e state;
  lbc_pkg::state_e state_next;

  lbc_pkg::req_t              cur;
  logic [lbc_pkg::SLOTS-1:0]  match_vec;
  logic [lbc_pkg::SLOTS-1:0]  free_vec;
  lbc_pkg::stat_t             stat [lbc_pkg::SLOTS];
  logic [lbc_pkg::SLOTS-1:0]  match_now;
  logic [lbc_pkg::SLOTS-1:0]  free_now;
  logic [lbc_pkg::SLOTS-1:0]  sel;
  lbc_pkg::upd_t              upd;

  logic                        hit_any;
  logic                        free_any;
  logic [lbc_pkg::RANK_W-1:0]  hit_rank;
  logic [lbc_pkg::RANK_W-1:0]  free_rank;
  logic [lbc_pkg::SLOT_W-1:0]  sel_idx;
  logic [lbc_pkg::COUNT_W-1:0] sel_count;
  logic                        sel_valid;
  logic [lbc_pkg::RANK_W-1:0]  sel_rank;
  logic                        in_range;
  lbc_pkg::cell_op_e           op_pre;
  logic                        shift_pre;
  lbc_pkg::rsp_t               result;
  logic                        fire;

  // Row of entry cells.
  for (genvar i = 0; i < lbc_pkg::SLOTS; i++) begin : g_cell
    lbc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .rank_init  (lbc_pkg::RANK_W'(lbc_pkg::SLOTS - 1 - i)),
      .key_device (req.device),
      .key_block  (req.block_number),
      .upd        (upd),
      .sel        (sel[i]),
      .stat       (stat[i])
    );
  end

  // Merge the rank-indexed flags of all cells.
  always_comb begin
    match_now = '0;
    free_now  = '0;
    for (int i = 0; i < lbc_pkg::SLOTS; i++) begin
      match_now = match_now | stat[i].match_by_rank;
      free_now  = free_now | stat[i].free_by_rank;
    end
  end

  // Capture the request and the compare results when an item is accepted.
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cur       <= req;
      match_vec <= match_now;
      free_vec  <= free_now;
    end
  end

  // Lowest matching rank and highest free rank.
  always_comb begin
    hit_any   = |match_vec;
    free_any  = |free_vec;
    hit_rank  = '0;
    free_rank = '0;
    for (int r = lbc_pkg::SLOTS - 1; r >= 0; r--) begin
      if (match_vec[r]) hit_rank = lbc_pkg::RANK_W'(r);
    end
    for (int r = 0; r < lbc_pkg::SLOTS; r++) begin
      if (free_vec[r]) free_rank = lbc_pkg::RANK_W'(r);
    end
  end

  // Select the cell acted on: by rank for get, by slot number otherwise.
  always_comb begin
    in_range = (32'(cur.slot_in) < lbc_pkg::SLOTS);
    for (int i = 0; i < lbc_pkg::SLOTS; i++) begin
      if (cur.command == lbc_pkg::CMD_GET) begin
        if (hit_any) begin
          sel[i] = (stat[i].rank == hit_rank);
        end else begin
          sel[i] = free_any && (stat[i].rank == free_rank);
        end
      end else begin
        sel[i] = in_range && (32'(cur.slot_in) == i);
      end
    end
  end

  // Read back index, count, valid bit and rank of the selected cell.
  always_comb begin
    sel_idx   = '0;
    sel_count = '0;
    sel_valid = 1'b0;
    sel_rank  = '0;
    for (int i = 0; i < lbc_pkg::SLOTS; i++) begin
      if (sel[i]) begin
        sel_idx   = sel_idx | lbc_pkg::SLOT_W'(i);
        sel_count = sel_count | stat[i].count;
        sel_valid = sel_valid | stat[i].valid;
        sel_rank  = sel_rank | stat[i].rank;
      end
    end
  end

  // Work out the cell operation and the response for the current item.
  always_comb begin
    op_pre               = lbc_pkg::OP_NONE;
    shift_pre            = 1'b0;
    result.slot_out      = cur.slot_in;
    result.need_read     = 1'b0;
    result.hit           = 1'b0;
    result.ref_count_out = '0;
    result.error         = lbc_pkg::ERR_OK;
    case (cur.command)
      lbc_pkg::CMD_GET: begin
        result.slot_out = sel_idx;
        if (hit_any) begin
          if (sel_count == lbc_pkg::COUNT_MAX) begin
            result.ref_count_out = lbc_pkg::COUNT_MAX;
            result.error         = lbc_pkg::ERR_OVERFLOW;
          end else begin
            op_pre               = lbc_pkg::OP_HIT;
            result.ref_count_out = sel_count + 1'b1;
            result.need_read     = !sel_valid;
            result.hit           = 1'b1;
          end
        end else if (free_any) begin
          op_pre               = lbc_pkg::OP_FILL;
          result.ref_count_out = lbc_pkg::COUNT_W'(1);
          result.need_read     = 1'b1;
        end else begin
          result.slot_out = '0;
          result.error    = lbc_pkg::ERR_NO_FREE;
        end
      end
      lbc_pkg::CMD_PIN: begin
        if (in_range) begin
          if (sel_count == lbc_pkg::COUNT_MAX) begin
            result.ref_count_out = lbc_pkg::COUNT_MAX;
            result.error         = lbc_pkg::ERR_OVERFLOW;
          end else begin
            op_pre               = lbc_pkg::OP_INC;
            result.ref_count_out = sel_count + 1'b1;
          end
        end
      end
      lbc_pkg::CMD_RELEASE, lbc_pkg::CMD_UNPIN: begin
        if (in_range) begin
          if (sel_count == '0) begin
            result.error = lbc_pkg::ERR_UNDERFLOW;
          end else begin
            result.ref_count_out = sel_count - 1'b1;
            if ((cur.command == lbc_pkg::CMD_RELEASE) &&
                (sel_count == lbc_pkg::COUNT_W'(1))) begin
              op_pre    = lbc_pkg::OP_FRONT;
              shift_pre = 1'b1;
            end else begin
              op_pre = lbc_pkg::OP_DEC;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      lbc_pkg::ST_IDLE: begin
        if (req_valid) state_next = lbc_pkg::ST_DECIDE;
      end
      lbc_pkg::ST_DECIDE: begin
        if (!rsp_valid || rsp_ready) state_next = lbc_pkg::ST_IDLE;
      end
      default: state_next = lbc_pkg::ST_IDLE;
    endcase
  end

  // State outputs: request ready, update strobe and broadcast.
  always_comb begin
    req_ready        = (state == lbc_pkg::ST_IDLE);
    fire             = (state == lbc_pkg::ST_DECIDE) && (!rsp_valid || rsp_ready);
    upd.op           = fire ? op_pre : lbc_pkg::OP_NONE;
    upd.shift        = fire && shift_pre;
    upd.old_rank     = sel_rank;
    upd.device       = cur.device;
    upd.block_number = cur.block_number;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= result;
    end
  end

endmodule

[tb/sv/lbc_checker.sv]
// Checker for the block buffer cache: tracks tags, counts and ranks of every entry,
// predicts each response from the accepted requests and compares field by field.
// Depends on lbc_pkg for the request and response structs and the codes.
module lbc_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_ready,
  input  lbc_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  lbc_pkg::rsp_t rsp,
  output int            fail_count,
  output int            pending
);

  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the cache entries.
  logic [lbc_pkg::DEV_W-1:0]   tag_dev  [lbc_pkg::SLOTS];
  logic [lbc_pkg::BLK_W-1:0]   tag_blk  [lbc_pkg::SLOTS];
  logic                        ent_valid[lbc_pkg::SLOTS];
  logic [lbc_pkg::COUNT_W-1:0] ref_cnt  [lbc_pkg::SLOTS];
  logic [lbc_pkg::RANK_W-1:0]  rank_of  [lbc_pkg::SLOTS];

  lbc_pkg::rsp_t rsp_expect_q[$];
  lbc_pkg::rsp_t want;
  int            i;

  // The released entry goes to rank 0; entries ranked ahead of it move back by one.
  function automatic void move_to_front(input int s);
    logic [lbc_pkg::RANK_W-1:0] old;
    old = rank_of[s];
    for (int k = 0; k < lbc_pkg::SLOTS; k++) begin
      if (rank_of[k] < old) rank_of[k] = rank_of[k] + 1'b1;
    end
    rank_of[s] = '0;
  endfunction

  // Applies one request to the shadow cache and returns the response it must give.
  function automatic lbc_pkg::rsp_t cache_apply(input lbc_pkg::req_t r);
    lbc_pkg::rsp_t o;
    bit            found;
    int            pick;
    int            s;
    o          = '0;
    o.slot_out = r.slot_in;
    o.error    = lbc_pkg::ERR_OK;
    found      = 1'b0;
    pick       = 0;
    if (r.command == lbc_pkg::CMD_GET) begin
      // A tag match wins, taking the most recently released of the matches.
      for (int k = 0; k < lbc_pkg::SLOTS; k++) begin
        if (tag_dev[k] == r.device && tag_blk[k] == r.block_number &&
            (!found || rank_of[k] < rank_of[pick])) begin
          pick  = k;
          found = 1'b1;
        end
      end
      if (found) begin
        o.slot_out = lbc_pkg::SLOT_W'(pick);
        if (ref_cnt[pick] == lbc_pkg::COUNT_MAX) begin
          o.ref_count_out = lbc_pkg::COUNT_MAX;
          o.error         = lbc_pkg::ERR_OVERFLOW;
        end else begin
          ref_cnt[pick]   = ref_cnt[pick] + 1'b1;
          o.need_read     = !ent_valid[pick];
          ent_valid[pick] = 1'b1;
          o.hit           = 1'b1;
          o.ref_count_out = ref_cnt[pick];
        end
        return o;
      end
      // On a miss, reuse the unreferenced entry released longest ago.
      for (int k = 0; k < lbc_pkg::SLOTS; k++) begin
        if (ref_cnt[k] == '0 && (!found || rank_of[k] > rank_of[pick])) begin
          pick  = k;
          found = 1'b1;
        end
      end
      if (!found) begin
        o.slot_out = '0;
        o.error    = lbc_pkg::ERR_NO_FREE;
        return o;
      end
      tag_dev[pick]   = r.device;
      tag_blk[pick]   = r.block_number;
      ref_cnt[pick]   = lbc_pkg::COUNT_W'(1);
      ent_valid[pick] = 1'b1;
      o.slot_out      = lbc_pkg::SLOT_W'(pick);
      o.need_read     = 1'b1;
      o.ref_count_out = lbc_pkg::COUNT_W'(1);
      return o;
    end
    s = int'(r.slot_in);
    if (s >= lbc_pkg::SLOTS) return o;
    if (r.command == lbc_pkg::CMD_PIN) begin
      if (ref_cnt[s] == lbc_pkg::COUNT_MAX) begin
        o.ref_count_out = lbc_pkg::COUNT_MAX;
        o.error         = lbc_pkg::ERR_OVERFLOW;
      end else begin
        ref_cnt[s]      = ref_cnt[s] + 1'b1;
        o.ref_count_out = ref_cnt[s];
      end
      return o;
    end
    // Release and unpin both drop a reference; only release touches the ranks.
    if (ref_cnt[s] == '0) begin
      o.error = lbc_pkg::ERR_UNDERFLOW;
      return o;
    end
    ref_cnt[s] = ref_cnt[s] - 1'b1;
    if (r.command == lbc_pkg::CMD_RELEASE && ref_cnt[s] == '0) move_to_front(s);
    o.ref_count_out = ref_cnt[s];
    return o;
  endfunction

  function automatic void check_field(input string fname, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, fname, exp_v, act_v);
    end
  endfunction

  // Responses are compared before the same edge's request is predicted.
  always @(posedge clk) begin
    if (rst) begin
      for (i = 0; i < lbc_pkg::SLOTS; i++) begin
        tag_dev[i]   = '0;
        tag_blk[i]   = '0;
        ent_valid[i] = 1'b0;
        ref_cnt[i]   = '0;
        rank_of[i]   = lbc_pkg::RANK_W'(lbc_pkg::SLOTS - 1 - i);
      end
      rsp_expect_q.delete();
      fail_count = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (rsp_expect_q.size() == 0) begin
          fail_count++;
          $display("%0t: response with none expected: expected nothing, actual %0h",
                   $time, rsp);
        end else begin
          want = rsp_expect_q.pop_front();
          check_field("slot_out", 32'(want.slot_out), 32'(rsp.slot_out));
          check_field("need_read", 32'(want.need_read), 32'(rsp.need_read));
          check_field("hit", 32'(want.hit), 32'(rsp.hit));
          check_field("ref_count_out", 32'(want.ref_count_out), 32'(rsp.ref_count_out));
          check_field("error", 32'(want.error), 32'(rsp.error));
        end
      end
      if (req_valid && req_ready) rsp_expect_q.push_back(cache_apply(req));
    end
    pending = rsp_expect_q.size();
  end

endmodule

[tb/sv/tb.sv]
// Top of the block buffer cache testbench: clock, reset, request stimulus and
// response stalls; the verdict comes from lbc_checker. Depends on lbc_pkg and the RTL.
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 400;
  localparam int CYCLE_LIMIT  = 300000;

  logic          clk;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_ready;
  lbc_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  lbc_pkg::rsp_t rsp;

  int   fail_count;
  int   pending;
  int   cycles  = 0;
  int   stall   = 0;
  bit   idle_on = 1'b1;

  // Commands in flight, and slots that currently hold a reference from a get or pin.
  lbc_pkg::cmd_e              cmd_q[$];
  logic [lbc_pkg::SLOT_W-1:0] held[$];
  logic [lbc_pkg::SLOT_W-1:0] last_get_slot = '0;

  lru_block_buffer_cache_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  lbc_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit in case the handshake hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** lru_block_buffer_cache_top: FAILED **");
      $finish;
    end
  end

  // Remember which slots gets handed out so releases can return them.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready && cmd_q.size() > 0) begin
      if (cmd_q.pop_front() == lbc_pkg::CMD_GET && rsp.error == lbc_pkg::ERR_OK) begin
        last_get_slot = rsp.slot_out;
        if (held.size() < 64) held.push_back(rsp.slot_out);
      end
    end
  end

  // Response side stalls in random bursts while idling is on.
  initial begin
    forever begin
      @(negedge clk);
      if (stall == 0 && idle_on && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 11);
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        stall--;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  function automatic lbc_pkg::req_t make_req(input lbc_pkg::cmd_e c,
                                             input logic [lbc_pkg::DEV_W-1:0] d,
                                             input logic [lbc_pkg::BLK_W-1:0] b,
                                             input logic [lbc_pkg::SLOT_W-1:0] s);
    lbc_pkg::req_t r;
    r.command      = c;
    r.device       = d;
    r.block_number = b;
    r.slot_in      = s;
    return r;
  endfunction

  // Mostly a slot that holds a reference, sometimes any slot at all.
  function automatic logic [lbc_pkg::SLOT_W-1:0] held_slot(input bit take);
    int                         idx;
    logic [lbc_pkg::SLOT_W-1:0] s;
    if (held.size() == 0 || $urandom_range(0, 4) == 0) begin
      return lbc_pkg::SLOT_W'($urandom_range(0, 31));
    end
    idx = $urandom_range(0, held.size() - 1);
    s   = held[idx];
    if (take) held.delete(idx);
    return s;
  endfunction

  // Offers one item, with an optional idle burst ahead of it, and waits for acceptance.
  task automatic send_item(input lbc_pkg::req_t r);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    cmd_q.push_back(r.command);
  endtask

  // Holds the sender off until every outstanding response has come back.
  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  initial begin
    logic [lbc_pkg::SLOT_W-1:0] s;
    logic [lbc_pkg::DEV_W-1:0]  d;
    logic [lbc_pkg::BLK_W-1:0]  b;
    int                         k;
    int                         n;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero tags after reset, extreme tags, every command, underflow.
    send_item(make_req(lbc_pkg::CMD_GET, 8'h00, 32'h0000_0000, 5'd0));
    send_item(make_req(lbc_pkg::CMD_GET, 8'h00, 32'h0000_0000, 5'd31));
    send_item(make_req(lbc_pkg::CMD_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31));
    send_item(make_req(lbc_pkg::CMD_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd0));
    send_item(make_req(lbc_pkg::CMD_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0));
    send_item(make_req(lbc_pkg::CMD_PIN, 8'h00, 32'h0000_0000, 5'd31));
    send_item(make_req(lbc_pkg::CMD_UNPIN, 8'h00, 32'h0000_0000, 5'd31));
    send_item(make_req(lbc_pkg::CMD_RELEASE, 8'h00, 32'h0000_0000, 5'd31));
    send_item(make_req(lbc_pkg::CMD_RELEASE, 8'h00, 32'h0000_0000, 5'd31));
    send_item(make_req(lbc_pkg::CMD_RELEASE, 8'h00, 32'h0000_0000, 5'd7));
    send_item(make_req(lbc_pkg::CMD_UNPIN, 8'h00, 32'h0000_0000, 5'd7));
    send_item(make_req(lbc_pkg::CMD_PIN, 8'h00, 32'h0000_0000, 5'd7));
    send_item(make_req(lbc_pkg::CMD_RELEASE, 8'h00, 32'h0000_0000, 5'd7));
    send_item(make_req(lbc_pkg::CMD_GET, 8'h00, 32'h0000_0000, 5'd7));
    send_item(make_req(lbc_pkg::CMD_GET, 8'h80, 32'h8000_0000, 5'd16));
    drain();

    // Count overflow: take a fresh block, pin it to the top, then pin and get once more.
    send_item(make_req(lbc_pkg::CMD_GET, 8'h5A, 32'h0BAD_F00D, 5'd0));
    drain();
    s = last_get_slot;
    repeat (254) send_item(make_req(lbc_pkg::CMD_PIN, 8'h00, 32'h0, s));
    send_item(make_req(lbc_pkg::CMD_PIN, 8'h00, 32'h0, s));
    send_item(make_req(lbc_pkg::CMD_GET, 8'h5A, 32'h0BAD_F00D, 5'd0));
    send_item(make_req(lbc_pkg::CMD_UNPIN, 8'h00, 32'h0, s));
    send_item(make_req(lbc_pkg::CMD_PIN, 8'h00, 32'h0, s));

    // Fill the cache with distinct blocks until no free buffer is left, then give them back.
    for (k = 0; k < 34; k++) begin
      send_item(make_req(lbc_pkg::CMD_GET, 8'hC3, 32'hF000_0000 + k, 5'(k)));
    end
    drain();
    while (held.size() > 0) begin
      send_item(make_req(lbc_pkg::CMD_RELEASE, 8'h00, 32'h0, held.pop_front()));
    end
    drain();

    // Random traffic over a small set of tags so that hits, reuse and releases recur.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (n >= RANDOM_ITEMS - 100) idle_on = 1'b0;
      d = ($urandom_range(0, 3) == 0) ? lbc_pkg::DEV_W'($urandom_range(0, 255))
                                      : lbc_pkg::DEV_W'($urandom_range(0, 2));
      b = ($urandom_range(0, 3) == 0) ? lbc_pkg::BLK_W'($urandom)
                                      : lbc_pkg::BLK_W'($urandom_range(0, 5));
      k = $urandom_range(0, 99);
      if (k < 40) begin
        send_item(make_req(lbc_pkg::CMD_GET, d, b, lbc_pkg::SLOT_W'($urandom_range(0, 31))));
      end else if (k < 70) begin
        send_item(make_req(lbc_pkg::CMD_RELEASE, d, b, held_slot(1'b1)));
      end else if (k < 85) begin
        s = held_slot(1'b0);
        if (held.size() < 64) held.push_back(s);
        send_item(make_req(lbc_pkg::CMD_PIN, d, b, s));
      end else begin
        send_item(make_req(lbc_pkg::CMD_UNPIN, d, b, held_slot(1'b1)));
      end
    end

    @(negedge clk);
    req_valid <= 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("** lru_block_buffer_cache_top: PASSED **");
    end else begin
      $display("** lru_block_buffer_cache_top: FAILED **");
    end
    $finish;
  end

endmodule
